/* src/tmtw_pkg.sv */
`default_nettype none
package tmtw_pkg;

	// character codes
	localparam logic [7:0] BLANK_CHAR   = 8'h20;
	localparam logic [7:0] NEWLINE_CHAR = 8'h0a;
	localparam logic [7:0] TAB_CHAR     = 8'h09;

	// colour of the screen after reset and of text_color after reset
	localparam logic [7:0] RESET_COLOR = 8'h07;

	// columns skipped by a tab
	localparam int unsigned TAB_STEP = 4;

	// command modes
	localparam logic [1:0] MODE_PUT   = 2'd0;
	localparam logic [1:0] MODE_WRITE = 2'd1;
	localparam logic [1:0] MODE_READ  = 2'd2;

endpackage
`default_nettype wire

/* src/text_mode_terminal_writer.sv */
`default_nettype none
// channel   | signals                                   | beat taken when
// ----------+-------------------------------------------+--------------------------
// command   | start, busy, mode, char_code, cell_color, | start high and busy low
//           | cell_column, cell_row                     |
// result    | done, read_entry, cursor_row,             | every cycle done is high
//           | cursor_column, scrolled                   | (one cycle, no back-pressure)
// config    | cfg_valid, cfg_ready, cfg_data            | cfg_valid and cfg_ready high
//
// a command passes through accept, decode, memory access and result strobe
// a put that scrolls adds a blanking pass: the one memory port blanks the old top row
// rows live in the store as a ring, so a scroll moves no data, only the top-row pointer
// after reset the store is swept to blank cells, one cell a cycle, over all SCREEN_COLUMNS *
// SCREEN_ROWS cells; busy stays high until the sweep ends
// the result strobe cannot be stalled; config writes are always ready
module text_mode_terminal_writer
	import tmtw_pkg::*;
#(
	parameter int SCREEN_COLUMNS = 80,
	parameter int SCREEN_ROWS    = 25
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// command beat
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  mode,
	input  wire logic [7:0]  char_code,
	input  wire logic [7:0]  cell_color,
	input  wire logic [6:0]  cell_column,
	input  wire logic [4:0]  cell_row,
	// result beat
	output logic             done,
	output logic [15:0]      read_entry,
	output logic [4:0]       cursor_row,
	output logic [6:0]       cursor_column,
	output logic             scrolled,
	// config beat
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [7:0]  cfg_data
);

	localparam int CELLS  = SCREEN_COLUMNS * SCREEN_ROWS;
	localparam int ADDR_W = $clog2(CELLS);
	localparam int COL_W  = $clog2(SCREEN_COLUMNS);
	localparam int ROW_W  = $clog2(SCREEN_ROWS);

	// sequencer codes
	localparam logic [2:0] ST_CLEAR  = 3'd0;
	localparam logic [2:0] ST_IDLE   = 3'd1;
	localparam logic [2:0] ST_CALC   = 3'd2;
	localparam logic [2:0] ST_ACCESS = 3'd3;
	localparam logic [2:0] ST_SCROLL = 3'd4;
	localparam logic [2:0] ST_RESP   = 3'd5;

	// logical row to ring position
	function automatic logic [ROW_W-1:0] wrap_row(input logic [ROW_W-1:0] a,
		input logic [ROW_W-1:0] b);
		logic [ROW_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= (ROW_W+1)'(SCREEN_ROWS)) begin
			s = s - (ROW_W+1)'(SCREEN_ROWS);
		end
		return s[ROW_W-1:0];
	endfunction

	logic [2:0]        state_q;
	logic [7:0]        text_color_q;

	// latched command
	logic [1:0]        mode_q;
	logic [7:0]        char_q;
	logic [7:0]        color_q;
	logic [6:0]        col_in_q;
	logic [4:0]        row_in_q;

	// cursor (logical) and ring position of the top row
	logic [ROW_W-1:0]  cur_row_q;
	logic [COL_W-1:0]  cur_col_q;
	logic [ROW_W-1:0]  base_q;

	// decoded access
	logic [ROW_W-1:0]  acc_row_q;
	logic [COL_W-1:0]  acc_col_q;
	logic              acc_we_q;
	logic              acc_rd_q;
	logic [15:0]       acc_data_q;
	logic              scroll_q;

	logic [ADDR_W-1:0] clr_cnt_q;
	logic [COL_W-1:0]  sc_cnt_q;

	logic [15:0]       screen_mem_q [CELLS];
	logic [15:0]       rd_data_q;

	// decode helpers
	logic              in_cell;
	logic [COL_W+6:0]  col_in_ext;
	logic [ROW_W+4:0]  row_in_ext;
	logic [COL_W-1:0]  col_in_n;
	logic [ROW_W-1:0]  row_in_n;
	logic [COL_W:0]    col_p1;
	logic [COL_W:0]    col_p4;
	logic [ROW_W:0]    row_p1;
	logic              last_row;
	logic [ROW_W-1:0]  cur_phys;

	// next decode values
	logic [ROW_W-1:0]  n_acc_row;
	logic [COL_W-1:0]  n_acc_col;
	logic              n_acc_we;
	logic              n_acc_rd;
	logic [15:0]       n_acc_data;
	logic              n_newline;
	logic [COL_W-1:0]  n_cur_col;
	logic [ROW_W-1:0]  n_cur_row;
	logic              n_scroll;

	// memory port
	logic [ROW_W-1:0]  port_row;
	logic [COL_W-1:0]  port_col;
	logic [ADDR_W-1:0] mem_addr;
	logic              mem_we;
	logic [15:0]       mem_wdata;

	// output widening
	logic [ROW_W+4:0]  row_out_ext;
	logic [COL_W+6:0]  col_out_ext;

	assign in_cell = (32'(col_in_q) < SCREEN_COLUMNS) && (32'(row_in_q) < SCREEN_ROWS);
	assign col_in_ext = (COL_W+7)'(col_in_q);
	assign row_in_ext = (ROW_W+5)'(row_in_q);
	assign col_in_n = col_in_ext[COL_W-1:0];
	assign row_in_n = row_in_ext[ROW_W-1:0];
	assign col_p1 = (COL_W+1)'(cur_col_q) + (COL_W+1)'(1);
	assign col_p4 = (COL_W+1)'(cur_col_q) + (COL_W+1)'(TAB_STEP);
	assign row_p1 = (ROW_W+1)'(cur_row_q) + (ROW_W+1)'(1);
	assign last_row = row_p1 >= (ROW_W+1)'(SCREEN_ROWS);
	assign cur_phys = wrap_row(cur_row_q, base_q);

	// decode one command into at most one store access and the new cursor
	always_comb begin
		n_acc_row = cur_phys;
		n_acc_col = cur_col_q;
		n_acc_we = 1'b0;
		n_acc_rd = 1'b0;
		n_acc_data = {text_color_q, char_q};
		n_newline = 1'b0;
		n_cur_col = cur_col_q;
		n_cur_row = cur_row_q;
		n_scroll = 1'b0;
		unique case (mode_q)
			MODE_PUT: begin
				if (char_q == NEWLINE_CHAR) begin
					n_newline = 1'b1;
				end else if (char_q == TAB_CHAR) begin
					// tab moves without writing
					if (col_p4 >= (COL_W+1)'(SCREEN_COLUMNS)) begin
						n_newline = 1'b1;
					end else begin
						n_cur_col = col_p4[COL_W-1:0];
					end
				end else begin
					n_acc_we = 1'b1;
					if (col_p1 >= (COL_W+1)'(SCREEN_COLUMNS)) begin
						n_newline = 1'b1;
					end else begin
						n_cur_col = col_p1[COL_W-1:0];
					end
				end
				if (n_newline) begin
					n_cur_col = '0;
					// at the last row the cursor stays put and the screen scrolls
					if (last_row) begin
						n_scroll = 1'b1;
					end else begin
						n_cur_row = row_p1[ROW_W-1:0];
					end
				end
			end
			MODE_WRITE: begin
				n_acc_we = in_cell;
				n_acc_row = wrap_row(row_in_n, base_q);
				n_acc_col = col_in_n;
				n_acc_data = {color_q, char_q};
			end
			MODE_READ: begin
				n_acc_rd = in_cell;
				n_acc_row = wrap_row(row_in_n, base_q);
				n_acc_col = col_in_n;
			end
			default: begin
				// unused mode: nothing changes
			end
		endcase
	end

	// one store port shared by the sweep, the command access and the scroll blanking
	always_comb begin
		port_row = acc_row_q;
		port_col = acc_col_q;
		mem_we = 1'b0;
		mem_wdata = acc_data_q;
		unique case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
				mem_wdata = {RESET_COLOR, BLANK_CHAR};
			end
			ST_ACCESS: begin
				mem_we = acc_we_q;
			end
			ST_SCROLL: begin
				// old top row becomes the new bottom row
				port_row = base_q;
				port_col = sc_cnt_q;
				mem_we = 1'b1;
				mem_wdata = {text_color_q, BLANK_CHAR};
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
		if (state_q == ST_CLEAR) begin
			mem_addr = clr_cnt_q;
		end else begin
			mem_addr = ADDR_W'(port_row) * ADDR_W'(SCREEN_COLUMNS) + ADDR_W'(port_col);
		end
	end

	// screen store, registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			screen_mem_q[mem_addr] <= mem_wdata;
		end
		if (state_q == ST_ACCESS) begin
			rd_data_q <= screen_mem_q[mem_addr];
		end
	end

	// latched command and decoded access, no reset needed
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			mode_q <= mode;
			char_q <= char_code;
			color_q <= cell_color;
			col_in_q <= cell_column;
			row_in_q <= cell_row;
		end
		if (state_q == ST_CALC) begin
			acc_row_q <= n_acc_row;
			acc_col_q <= n_acc_col;
			acc_data_q <= n_acc_data;
		end
	end

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			text_color_q <= RESET_COLOR;
			cur_row_q <= '0;
			cur_col_q <= '0;
			base_q <= '0;
			acc_we_q <= 1'b0;
			acc_rd_q <= 1'b0;
			scroll_q <= 1'b0;
			clr_cnt_q <= '0;
			sc_cnt_q <= '0;
		end else begin
			if (cfg_valid) begin
				text_color_q <= cfg_data;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + ADDR_W'(1);
					if (clr_cnt_q == ADDR_W'(CELLS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_CALC;
					end
				end
				ST_CALC: begin
					acc_we_q <= n_acc_we;
					acc_rd_q <= n_acc_rd;
					scroll_q <= n_scroll;
					cur_row_q <= n_cur_row;
					cur_col_q <= n_cur_col;
					state_q <= ST_ACCESS;
				end
				ST_ACCESS: begin
					sc_cnt_q <= '0;
					state_q <= scroll_q ? ST_SCROLL : ST_RESP;
				end
				ST_SCROLL: begin
					sc_cnt_q <= sc_cnt_q + COL_W'(1);
					if (sc_cnt_q == COL_W'(SCREEN_COLUMNS - 1)) begin
						base_q <= wrap_row(base_q, ROW_W'(1));
						state_q <= ST_RESP;
					end
				end
				ST_RESP: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign row_out_ext = (ROW_W+5)'(cur_row_q);
	assign col_out_ext = (COL_W+7)'(cur_col_q);

	assign busy = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign done = (state_q == ST_RESP);
	assign read_entry = acc_rd_q ? rd_data_q : 16'h0000;
	assign cursor_row = row_out_ext[4:0];
	assign cursor_column = col_out_ext[6:0];
	assign scrolled = scroll_q;

endmodule
`default_nettype wire
